@@ rtl/cxl_pkg.sv @@
// Shared constants, codes and coefficient table for the cycloid X/Y LFO.
package cxl_pkg;

    // Default geometry
    localparam int PHASE_BITS_DEF = 32;
    localparam int SINE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int INC_W     = 32;
    localparam int AMT_W     = 17;
    localparam int DEPTH_W   = 19;
    localparam int GAIN_W    = 18;
    localparam int VOLT_W    = 16;
    localparam int RATIO_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MODE = 3'd0,
        CFG_RATIO_FREE = 3'd1,
        CFG_MUSICAL    = 3'd2,
        CFG_WOB_PHASE  = 3'd3,
        CFG_X_UNI      = 3'd4,
        CFG_Y_UNI      = 3'd5
    } cfg_idx_t;

    // Ratio range modes
    localparam logic [1:0] RANGE_INWARD  = 2'd0;
    localparam logic [1:0] RANGE_BIDIR   = 2'd1;
    localparam logic [1:0] RANGE_OUTWARD = 2'd2;

    // Sine sequencer steps
    localparam logic [2:0] SINE_SQ   = 3'd0;
    localparam logic [2:0] SINE_SEED = 3'd1;
    localparam logic [2:0] SINE_OUT  = 3'd6;

    // Mix sequencer steps
    localparam logic [2:0] MIX_THROB = 3'd0;
    localparam logic [2:0] MIX_WOB   = 3'd1;
    localparam logic [2:0] MIX_HI    = 3'd2;
    localparam logic [2:0] MIX_LO    = 3'd3;
    localparam logic [2:0] MIX_SAT   = 3'd4;

    // Sine result slots
    localparam logic [1:0] SIN_TC = 2'd0;
    localparam logic [1:0] SIN_TS = 2'd1;
    localparam logic [1:0] SIN_WC = 2'd2;
    localparam logic [1:0] SIN_WS = 2'd3;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [32:0] Q30_ONE      = 33'h0_4000_0000;
    localparam logic [32:0] POLY_SEED    = 33'd3864;

    // Odd Taylor coefficients, Q30, highest order first after the seed
    function automatic logic [31:0] poly_coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            3'd1:    c = 32'd172272;
            3'd2:    c = 32'd5026995;
            3'd3:    c = 32'd85569306;
            3'd4:    c = 32'd693598668;
            3'd5:    c = 32'd1686629713;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/cycloid_xy_lfo.sv @@
// Cycloid X/Y LFO: throb and wobble rotors mixed into an X/Y voltage pair.
// Per item: phase update, then four sines in turn on the shared 33x33 multiplier
//   (angle fold, square, Horner steps, output scale), X and Y mix, handoff.
// in_stall is high outside idle: one item at a time on the single shared multiplier.
// Reset (rst_n low, async): phases cleared, registers to defaults, output empty.
// A new result waits in the handoff state until the previous one is taken.
module cycloid_xy_lfo #(
    parameter int PHASE_BITS = cxl_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS  = cxl_pkg::SINE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cxl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cxl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [cxl_pkg::INC_W-1:0]     throb_increment,
    input  logic [cxl_pkg::AMT_W-1:0]            ratio_amount,
    input  logic signed [cxl_pkg::DEPTH_W-1:0]   depth_amount,
    input  logic [cxl_pkg::GAIN_W-1:0]           x_gain,
    input  logic [cxl_pkg::GAIN_W-1:0]           y_gain,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cxl_pkg::VOLT_W-1:0]    x_volts,
    output logic signed [cxl_pkg::VOLT_W-1:0]    y_volts
);
    import cxl_pkg::*;

    // Sine value: +/- 2^SINE_BITS
    localparam int SW   = SINE_BITS + 2;
    // Depth mix, including the unipolar lift
    localparam int MIXW = SINE_BITS + 19;
    // Upper bits of the mix above bit 20, split off for the gain multiply
    localparam int HI_W = MIXW - 21;
    // Mix times gain times five
    localparam int VW   = MIXW + 21;
    // Rounded volts before saturation
    localparam int RW   = VW - 22 - SINE_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PHASE  = 6'b000010,
        ST_ANGLE  = 6'b000100,
        ST_SINE   = 6'b001000,
        ST_MIX    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // ------------------------------------------------------------------
    // Control and configuration state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] sidx_reg, sidx_next;
    logic       chan_reg, chan_next;
    logic       out_valid_reg, out_valid_next;

    logic [1:0]  ratio_range_mode_reg;
    logic        ratio_free_reg;
    logic        musical_ratios_reg;
    logic [15:0] wobble_phase_knob_reg;
    logic        x_unipolar_reg;
    logic        y_unipolar_reg;

    logic [PHASE_BITS-1:0] throb_phase_reg, throb_phase_next;
    logic [PHASE_BITS-1:0] wobble_phase_reg, wobble_phase_next;

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    logic signed [INC_W-1:0]   inc_reg, inc_next;
    logic signed [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [16:0]               d_reg, d_next;
    logic [GAIN_W-1:0]         xg_reg, xg_next, yg_reg, yg_next;
    logic [30:0]               x_reg, x_next;
    logic                      neg_reg, neg_next;
    logic [30:0]               x2_reg, x2_next;
    logic [31:0]               t_reg, t_next;
    logic signed [SW-1:0]      tc_reg, tc_next, ts_reg, ts_next;
    logic signed [SW-1:0]      wc_reg, wc_next, ws_reg, ws_next;
    logic signed [MIXW-1:0]    mix_reg, mix_next;
    logic signed [VW-1:0]      v_reg, v_next;
    logic signed [VOLT_W-1:0]  xres_reg, xres_next, yres_reg, yres_next;
    logic signed [VOLT_W-1:0]  x_volts_reg, x_volts_next, y_volts_reg, y_volts_next;

    logic in_xfer;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign x_volts   = x_volts_reg;
    assign y_volts   = y_volts_reg;

    // ------------------------------------------------------------------
    // Wobble ratio (Q16) and clamped depth, formed at the input transfer
    // ------------------------------------------------------------------
    logic signed [RATIO_W-1:0] r_raw, r_mus, r_pos, r_mag, r_fin;
    logic [16:0]               d_clamp;

    always_comb
    begin
        case (ratio_range_mode_reg)
            RANGE_INWARD:
            begin
                r_raw = $signed({3'b000, ratio_amount, 4'b0000});
            end
            RANGE_BIDIR:
            begin
                r_raw = 24'sd1048576 - $signed({2'b00, ratio_amount, 5'b00000});
            end
            default:
            begin
                // outward, and the unused code behaves the same
                r_raw = -$signed({3'b000, ratio_amount, 4'b0000});
            end
        endcase
        r_mus = musical_ratios_reg ? r_raw : r_raw + 24'sd65536;
        r_pos = r_mus + 24'sd32768;
        r_mag = -r_mus + 24'sd32768;
        // Whole-number ratios round halves away from zero
        if (ratio_free_reg)
        begin
            r_fin = r_mus;
        end
        else if (!r_mus[RATIO_W-1])
        begin
            r_fin = $signed({r_pos[RATIO_W-1:16], 16'h0000});
        end
        else
        begin
            r_fin = -$signed({r_mag[RATIO_W-1:16], 16'h0000});
        end

        if (depth_amount[DEPTH_W-1])
        begin
            d_clamp = 17'd0;
        end
        else if (depth_amount > 19'sd65536)
        begin
            d_clamp = 17'd65536;
        end
        else
        begin
            d_clamp = depth_amount[16:0];
        end
    end

    // ------------------------------------------------------------------
    // Rotor angles: 32-bit turns taken from the phase accumulators
    // ------------------------------------------------------------------
    logic signed [16:0]    off_raw, off_use;
    logic [PHASE_BITS-1:0] off_phase, wob_read;
    logic [31:0]           t_ang, w_ang, sel_ang;
    logic [30:0]           ang_x;
    logic [47:0]           inc48;
    logic [PHASE_BITS-1:0] tinc;

    always_comb
    begin
        // Knob center is zero offset; offset flips with a negative ratio
        off_raw   = $signed({1'b0, wobble_phase_knob_reg}) - 17'sd32768;
        off_use   = ratio_reg[RATIO_W-1] ? -off_raw : off_raw;
        off_phase = PHASE_BITS'(off_use[15:0]) << (PHASE_BITS - 16);
        wob_read  = wobble_phase_reg + off_phase;
        t_ang     = 32'({throb_phase_reg, 32'h0000_0000} >> PHASE_BITS);
        w_ang     = 32'({wob_read, 32'h0000_0000} >> PHASE_BITS);
        case (sidx_reg)
            SIN_TC:  sel_ang = t_ang + QUARTER_TURN;
            SIN_TS:  sel_ang = t_ang;
            SIN_WC:  sel_ang = w_ang + QUARTER_TURN;
            default: sel_ang = w_ang;
        endcase
        // Fold to the first quadrant; the odd quadrants mirror
        if (sel_ang[30])
        begin
            ang_x = 31'h4000_0000 - {1'b0, sel_ang[29:0]};
        end
        else
        begin
            ang_x = {1'b0, sel_ang[29:0]};
        end
        // Throb advance in 2^-48 turns, floored to the accumulator scale
        inc48 = {inc_reg, 16'h0000};
        tinc  = inc48[47 -: PHASE_BITS];
    end

    // ------------------------------------------------------------------
    // Shared 33x33 signed multiplier and its operand select
    // ------------------------------------------------------------------
    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_p;
    logic signed [SW-1:0]   thr_sel, wob_sel;
    logic [GAIN_W-1:0]      gain_sel;
    logic [20:0]            g5;
    logic signed [HI_W-1:0] mix_hi;
    logic [20:0]            mix_lo;
    logic [16:0]            d_inv;

    always_comb
    begin
        thr_sel  = chan_reg ? ts_reg : tc_reg;
        wob_sel  = chan_reg ? ws_reg : wc_reg;
        gain_sel = chan_reg ? yg_reg : xg_reg;
        g5       = {3'b000, gain_sel} + {1'b0, gain_sel, 2'b00};
        mix_hi   = mix_reg[MIXW-1:21];
        mix_lo   = mix_reg[20:0];
        d_inv    = 17'd65536 - d_reg;

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PHASE:
            begin
                mul_a = 33'(ratio_reg);
                mul_b = 33'(inc_reg);
            end
            ST_SINE:
            begin
                case (step_reg)
                    SINE_SQ:
                    begin
                        mul_a = {2'b00, x_reg};
                        mul_b = {2'b00, x_reg};
                    end
                    SINE_SEED:
                    begin
                        mul_a = POLY_SEED;
                        mul_b = {2'b00, x2_reg};
                    end
                    SINE_OUT:
                    begin
                        mul_a = {2'b00, x_reg};
                        mul_b = {1'b0, t_reg};
                    end
                    default:
                    begin
                        mul_a = {1'b0, t_reg};
                        mul_b = {2'b00, x2_reg};
                    end
                endcase
            end
            ST_MIX:
            begin
                case (step_reg)
                    MIX_THROB:
                    begin
                        mul_a = {16'h0000, d_inv};
                        mul_b = 33'(thr_sel);
                    end
                    MIX_WOB:
                    begin
                        mul_a = {16'h0000, d_reg};
                        mul_b = 33'(wob_sel);
                    end
                    MIX_HI:
                    begin
                        mul_a = 33'(mix_hi);
                        mul_b = {12'h000, g5};
                    end
                    MIX_LO:
                    begin
                        mul_a = {12'h000, mix_lo};
                        mul_b = {12'h000, g5};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Post-multiply arithmetic
    // ------------------------------------------------------------------
    logic [65:0]            rsum;
    logic [32:0]            s_full;
    logic [30:0]            s_clamp;
    logic [31:0]            s_sum;
    logic [SINE_BITS:0]     s_mag;
    logic signed [SW-1:0]   sin_val;
    logic [MIXW-1:0]        uni_term;
    logic [RW-1:0]          r_sh;
    logic signed [VOLT_W-1:0] sat_val;

    always_comb
    begin
        // Q30 product, rounded half up
        rsum    = mul_p + (66'd1 << 29);
        s_full  = rsum[62:30];
        s_clamp = (s_full > Q30_ONE) ? Q30_ONE[30:0] : s_full[30:0];
        s_sum   = {1'b0, s_clamp} + (32'd1 << (29 - SINE_BITS));
        s_mag   = s_sum[30 - SINE_BITS +: SINE_BITS + 1];
        sin_val = neg_reg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

        if (chan_reg ? y_unipolar_reg : x_unipolar_reg)
        begin
            uni_term = MIXW'(1) << (16 + SINE_BITS);
        end
        else
        begin
            uni_term = '0;
        end

        r_sh = v_reg[VW-1 -: RW];
        if ((&r_sh[RW-1:VOLT_W-1]) || !(|r_sh[RW-1:VOLT_W-1]))
        begin
            sat_val = r_sh[VOLT_W-1:0];
        end
        else
        begin
            sat_val = r_sh[RW-1] ? 16'sh8000 : 16'sh7FFF;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        sidx_next         = sidx_reg;
        chan_next         = chan_reg;
        out_valid_next    = out_valid_reg && out_stall;
        throb_phase_next  = throb_phase_reg;
        wobble_phase_next = wobble_phase_reg;
        inc_next          = inc_reg;
        ratio_next        = ratio_reg;
        d_next            = d_reg;
        xg_next           = xg_reg;
        yg_next           = yg_reg;
        x_next            = x_reg;
        neg_next          = neg_reg;
        x2_next           = x2_reg;
        t_next            = t_reg;
        tc_next           = tc_reg;
        ts_next           = ts_reg;
        wc_next           = wc_reg;
        ws_next           = ws_reg;
        mix_next          = mix_reg;
        v_next            = v_reg;
        xres_next         = xres_reg;
        yres_next         = yres_reg;
        x_volts_next      = x_volts_reg;
        y_volts_next      = y_volts_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    inc_next   = throb_increment;
                    ratio_next = r_fin;
                    d_next     = d_clamp;
                    xg_next    = x_gain;
                    yg_next    = y_gain;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                // Wobble advance = ratio * increment, in 2^-48 turns
                throb_phase_next  = throb_phase_reg + tinc;
                wobble_phase_next = wobble_phase_reg + mul_p[47 -: PHASE_BITS];
                sidx_next         = SIN_TC;
                state_next        = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                x_next     = ang_x;
                neg_next   = sel_ang[31];
                step_next  = SINE_SQ;
                state_next = ST_SINE;
            end
            ST_SINE:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    SINE_SQ:
                    begin
                        x2_next = rsum[60:30];
                    end
                    SINE_OUT:
                    begin
                        case (sidx_reg)
                            SIN_TC:  tc_next = sin_val;
                            SIN_TS:  ts_next = sin_val;
                            SIN_WC:  wc_next = sin_val;
                            default: ws_next = sin_val;
                        endcase
                        if (sidx_reg == SIN_WS)
                        begin
                            chan_next  = 1'b0;
                            step_next  = MIX_THROB;
                            state_next = ST_MIX;
                        end
                        else
                        begin
                            sidx_next  = sidx_reg + 2'd1;
                            state_next = ST_ANGLE;
                        end
                    end
                    default:
                    begin
                        // Horner step: t = c - t * x^2
                        t_next = poly_coef(step_reg) - rsum[61:30];
                    end
                endcase
            end
            ST_MIX:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    MIX_THROB:
                    begin
                        mix_next = mul_p[MIXW-1:0];
                    end
                    MIX_WOB:
                    begin
                        mix_next = mix_reg + mul_p[MIXW-1:0] + uni_term;
                    end
                    MIX_HI:
                    begin
                        // Rounding bias rides in with the upper partial product
                        v_next = (mul_p[VW-1:0] << 21) + (VW'(1) << (21 + SINE_BITS));
                    end
                    MIX_LO:
                    begin
                        v_next = v_reg + mul_p[VW-1:0];
                    end
                    MIX_SAT:
                    begin
                        if (chan_reg)
                        begin
                            yres_next  = sat_val;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            xres_next = sat_val;
                            chan_next = 1'b1;
                            step_next = MIX_THROB;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FINISH:
            begin
                // Wait here only while the previous result is still unclaimed
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    x_volts_next   = xres_reg;
                    y_volts_next   = yres_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control, phase and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            step_reg              <= '0;
            sidx_reg              <= '0;
            chan_reg              <= 1'b0;
            out_valid_reg         <= 1'b0;
            throb_phase_reg       <= '0;
            wobble_phase_reg      <= '0;
            ratio_range_mode_reg  <= RANGE_OUTWARD;
            ratio_free_reg        <= 1'b1;
            musical_ratios_reg    <= 1'b1;
            wobble_phase_knob_reg <= 16'h8000;
            x_unipolar_reg        <= 1'b0;
            y_unipolar_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            sidx_reg         <= sidx_next;
            chan_reg         <= chan_next;
            out_valid_reg    <= out_valid_next;
            throb_phase_reg  <= throb_phase_next;
            wobble_phase_reg <= wobble_phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANGE_MODE: ratio_range_mode_reg  <= cfg_data[1:0];
                    CFG_RATIO_FREE: ratio_free_reg        <= cfg_data[0];
                    CFG_MUSICAL:    musical_ratios_reg    <= cfg_data[0];
                    CFG_WOB_PHASE:  wobble_phase_knob_reg <= cfg_data;
                    CFG_X_UNI:      x_unipolar_reg        <= cfg_data[0];
                    CFG_Y_UNI:      y_unipolar_reg        <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        inc_reg     <= inc_next;
        ratio_reg   <= ratio_next;
        d_reg       <= d_next;
        xg_reg      <= xg_next;
        yg_reg      <= yg_next;
        x_reg       <= x_next;
        neg_reg     <= neg_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        tc_reg      <= tc_next;
        ts_reg      <= ts_next;
        wc_reg      <= wc_next;
        ws_reg      <= ws_next;
        mix_reg     <= mix_next;
        v_reg       <= v_next;
        xres_reg    <= xres_next;
        yres_reg    <= yres_next;
        x_volts_reg <= x_volts_next;
        y_volts_reg <= y_volts_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took no work after an input transfer");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result presented outside the handoff state");

    a_sine_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SINE) |-> (step_reg <= SINE_OUT))
        else $error("sine step counter ran past the last step");

    a_phase_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(throb_phase_reg) |-> $past(state_reg == ST_PHASE))
        else $error("throb phase moved outside the phase update");

endmodule

@@ dv/tb_cycloid_xy_lfo.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cycloid_xy_lfo: directed table, then randomized settings and items.
module tb_cycloid_xy_lfo;
    import cxl_pkg::*;

    // Run shape
    localparam int NUM_ROWS       = 16;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 60;     // idle time before the final report
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int IDLE_PCT       = 38;

    // Register indexes the block does not decode, and the range mode it does not name
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [1:0]           RANGE_UNUSED = 2'd3;

    // Sine polynomial, Q30
    localparam longint unsigned Q30_FULL  = 64'd1073741824;
    localparam longint unsigned Q30_RND   = 64'd536870912;
    localparam longint unsigned TAYLOR_SEED = 64'd3864;
    localparam longint unsigned TAYLOR_Q30 [5] = '{64'd172272, 64'd5026995, 64'd85569306,
                                                   64'd693598668, 64'd1686629713};

    typedef struct packed {
        logic signed [VOLT_W-1:0] x;
        logic signed [VOLT_W-1:0] y;
    } volt_pair_t;

    // One directed transfer; 'known' rows carry the expected volts typed in
    typedef struct packed {
        logic signed [INC_W-1:0]   inc;
        logic [AMT_W-1:0]          amt;
        logic signed [DEPTH_W-1:0] dep;
        logic [GAIN_W-1:0]         xg;
        logic [GAIN_W-1:0]         yg;
        logic                      known;
        logic signed [VOLT_W-1:0]  x;
        logic signed [VOLT_W-1:0]  y;
    } stim_row_t;

    // Rows 0..5 keep both rotors at phase zero (zero increment), so cos is one and sin
    // is zero: x = 5 V * gain * (1 mixed with 1), y = 0. They also hit the depth clamps
    // on both sides and the amount above full. The rest go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{32'sd0, 17'd0, 19'sd0, 18'd65536, 18'd65536, 1'b1, 16'sd5120, 16'sd0},
        '{32'sd0, 17'd0, 19'sd0, 18'd0, 18'd0, 1'b1, 16'sd0, 16'sd0},
        '{32'sd0, 17'd131071, 19'sd262143, 18'd262143, 18'd262143, 1'b1, 16'sd20480, 16'sd0},
        '{32'sd0, 17'd65536, -19'sd262144, 18'd131072, 18'd131072, 1'b1, 16'sd10240, 16'sd0},
        '{32'sd0, 17'd65536, 19'sd65536, 18'd131072, 18'd0, 1'b1, 16'sd10240, 16'sd0},
        '{32'sd0, 17'd32768, -19'sd65536, 18'd65536, 18'd262143, 1'b1, 16'sd5120, 16'sd0},
        '{32'sh4000_0000, 17'd0, 19'sd0, 18'd65536, 18'd65536, 1'b0, 16'sd0, 16'sd0},
        '{32'sh8000_0000, 17'd65536, 19'sd65536, 18'd131072, 18'd131072, 1'b0, 16'sd0, 16'sd0},
        '{32'sh7FFF_FFFF, 17'd131071, 19'sd32768, 18'd262143, 18'd262143, 1'b0, 16'sd0, 16'sd0},
        '{32'sd1, 17'd1, 19'sd1, 18'd1, 18'd1, 1'b0, 16'sd0, 16'sd0},
        '{-32'sd1, 17'd65535, 19'sd65535, 18'd131071, 18'd131071, 1'b0, 16'sd0, 16'sd0},
        '{32'sh0100_0000, 17'd2048, 19'sd32768, 18'd65536, 18'd65536, 1'b0, 16'sd0, 16'sd0},
        '{32'sh0010_0000, 17'd131071, 19'sd65536, 18'd65536, 18'd65536, 1'b0, 16'sd0, 16'sd0},
        '{-32'sh0040_0000, 17'd40000, 19'sd131072, 18'd131072, 18'd131072, 1'b0,
          16'sd0, 16'sd0},
        '{32'sh1234_5678, 17'd1024, 19'sh3_FFFF, 18'd200000, 18'd100000, 1'b0, 16'sd0, 16'sd0},
        '{-32'sh2000_0001, 17'd65536, 19'sd0, 18'd0, 18'd262143, 1'b0, 16'sd0, 16'sd0}
    };

    // DUT ports; every input has a known value from time zero
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [INC_W-1:0]   throb_increment = '0;
    logic [AMT_W-1:0]          ratio_amount = '0;
    logic signed [DEPTH_W-1:0] depth_amount = '0;
    logic [GAIN_W-1:0]         x_gain = '0;
    logic [GAIN_W-1:0]         y_gain = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VOLT_W-1:0]  x_volts;
    logic signed [VOLT_W-1:0]  y_volts;

    // Predictor copy of the registers and rotors
    logic [1:0]  range_sel;
    logic        keep_fraction;
    logic        musical;
    logic [15:0] wob_knob;
    logic        x_uni;
    logic        y_uni;
    logic [31:0] throb_ph;
    logic [31:0] wobble_ph;

    volt_pair_t volts_due [$];   // expected volts, oldest first
    int         err_count = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;     // suppresses idling on both sides

    cycloid_xy_lfo dut (.*);

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_model();
        range_sel     = RANGE_OUTWARD;
        keep_fraction = 1'b1;
        musical       = 1'b1;
        wob_knob      = 16'h8000;
        x_uni         = 1'b0;
        y_uni         = 1'b0;
        throb_ph      = '0;
        wobble_ph     = '0;
    endfunction

    // Unknown indexes fall through untouched
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_RANGE_MODE: range_sel     = val[1:0];
            CFG_RATIO_FREE: keep_fraction = val[0];
            CFG_MUSICAL:    musical       = val[0];
            CFG_WOB_PHASE:  wob_knob      = val;
            CFG_X_UNI:      x_uni         = val[0];
            CFG_Y_UNI:      y_uni         = val[0];
            default: ;
        endcase
    endfunction

    // Quarter-wave odd polynomial; angle in 2^-32 turn, result in Q16
    function automatic longint sine_q16(input logic [31:0] ang);
        logic [1:0]      quad;
        longint unsigned frac;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned s;
        int              k;
        quad = ang[31:30];
        frac = 64'(ang[29:0]);
        if (quad[0])
            frac = Q30_FULL - frac;
        sq  = (frac * frac + Q30_RND) >> 30;
        acc = TAYLOR_SEED;
        for (k = 0; k < 5; k++)
            acc = TAYLOR_Q30[k] - ((acc * sq + Q30_RND) >> 30);
        s = (frac * acc + Q30_RND) >> 30;
        if (s > Q30_FULL)
            s = Q30_FULL;
        s = (s + 64'd8192) >> 14;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Depth mix, unipolar lift, gain * 5 V, round half up, saturate
    function automatic logic signed [15:0] mix_to_volts(input longint throb, input longint wob,
                                                       input longint dep, input logic uni,
                                                       input logic [17:0] gain);
        longint mix;
        longint v;
        mix = (65536 - dep) * throb + dep * wob;
        if (uni)
            mix += 64'sd1 <<< 32;
        v = mix * longint'(gain) * 5;
        v = (v + (64'sd1 <<< 37)) >>> 38;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // One sample: advance both rotors and form the X/Y pair
    function automatic volt_pair_t advance_rotors(input logic signed [31:0] inc,
                                                  input logic [16:0] amt,
                                                  input logic signed [18:0] dep_raw,
                                                  input logic [17:0] xg, input logic [17:0] yg);
        volt_pair_t  res;
        longint      ratio;
        longint      off;
        longint      d;
        longint      wstep;
        logic [31:0] wa;
        d = longint'(dep_raw);
        if (d < 0)
            d = 0;
        if (d > 65536)
            d = 65536;
        case (range_sel)
            RANGE_INWARD: ratio = 16 * longint'(amt);
            RANGE_BIDIR:  ratio = 1048576 - 32 * longint'(amt);
            default:      ratio = -16 * longint'(amt);   // outward, and the unused mode
        endcase
        if (!musical)
            ratio += 65536;
        // whole ratios: halves round away from zero
        if (!keep_fraction) begin
            if (ratio >= 0)
                ratio = ((ratio + 32768) >>> 16) * 65536;
            else
                ratio = -(((-ratio + 32768) >>> 16) * 65536);
        end
        off = longint'(wob_knob) - 32768;
        if (ratio < 0)
            off = -off;
        wstep = (ratio * longint'(inc)) >>> 16;
        throb_ph  = throb_ph + inc;
        wobble_ph = wobble_ph + wstep[31:0];
        wa = wobble_ph + {off[15:0], 16'h0000};
        res.x = mix_to_volts(sine_q16(throb_ph + QUARTER_TURN), sine_q16(wa + QUARTER_TURN),
                             d, x_uni, xg);
        res.y = mix_to_volts(sine_q16(throb_ph), sine_q16(wa), d, y_uni, yg);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Present one item, hold it through stalls, predict on the accepting edge,
    // then maybe leave a random gap before the next one.
    task automatic push_item(input logic signed [31:0] inc, input logic [16:0] amt,
                             input logic signed [18:0] dep, input logic [17:0] xg,
                             input logic [17:0] yg, input bit typed, input volt_pair_t typed_val);
        volt_pair_t res;
        throb_increment <= inc;
        ratio_amount    <= amt;
        depth_amount    <= dep;
        x_gain          <= xg;
        y_gain          <= yg;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = advance_rotors(inc, amt, dep, xg, yg);
        volts_due.push_back(typed ? typed_val : res);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 50))
                @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected transfer has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (volts_due.size() != 0)
            @(posedge clk);
    endtask

    // cfg_we is left high; the caller lowers it once after a batch of writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    // Full register set plus a poke at both undecoded indexes
    task automatic load_setting(input logic [15:0] mode, input logic [15:0] free_v,
                                input logic [15:0] mus, input logic [15:0] knob,
                                input logic [15:0] xu, input logic [15:0] yu);
        write_reg(CFG_RANGE_MODE, mode);
        write_reg(CFG_RATIO_FREE, free_v);
        write_reg(CFG_MUSICAL, mus);
        write_reg(CFG_WOB_PHASE, knob);
        write_reg(CFG_X_UNI, xu);
        write_reg(CFG_Y_UNI, yu);
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly LFO-like slow increments and in-range knobs, with full-range noise mixed in
    task automatic send_random_item();
        logic signed [31:0] inc;
        logic [16:0]        amt;
        logic signed [18:0] dep;
        logic [17:0]        xg;
        logic [17:0]        yg;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            inc = 32'($urandom_range(0, 32'h00FF_FFFF));
            if ($urandom_range(1))
                inc = -inc;
        end else if (pick < 75)
            inc = $signed($urandom) >>> $urandom_range(0, 24);
        else
            inc = $urandom;

        pick = $urandom_range(99);
        if (pick < 70)
            amt = 17'($urandom_range(0, 65536));
        else if (pick < 80)   // ratio lands on a half in inward/outward or bidirectional
            amt = $urandom_range(1) ? 17'(2048 + 4096 * $urandom_range(0, 15))
                                    : 17'(1024 + 2048 * $urandom_range(0, 31));
        else if (pick < 90)   // above full
            amt = 17'($urandom_range(65537, 131071));
        else
            amt = $urandom_range(1) ? 17'd0 : ($urandom_range(1) ? 17'd65536 : 17'd131071);

        pick = $urandom_range(99);
        if (pick < 60)
            dep = 19'($urandom_range(0, 65536));
        else if (pick < 75)
            dep = $urandom_range(1) ? 19'sd0 : 19'sd65536;
        else
            dep = 19'($urandom);

        pick = $urandom_range(99);
        if (pick < 70) begin
            xg = 18'($urandom_range(0, 131072));
            yg = 18'($urandom_range(0, 131072));
        end else if (pick < 85) begin
            xg = 18'($urandom);
            yg = 18'($urandom);
        end else begin
            xg = $urandom_range(1) ? 18'd0 : 18'd262143;
            yg = $urandom_range(1) ? 18'd131072 : 18'd262143;
        end
        push_item(inc, amt, dep, xg, yg, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, checked on every accepted transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk) begin
        volt_pair_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (volts_due.size() == 0) begin
                $error("unexpected transfer: x_volts %0d y_volts %0d", x_volts, y_volts);
                err_count++;
            end else begin
                want = volts_due.pop_front();
                if (x_volts !== want.x) begin
                    $error("x_volts: expected %0d, got %0d", want.x, x_volts);
                    err_count++;
                end
                if (y_volts !== want.y) begin
                    $error("y_volts: expected %0d, got %0d", want.y, y_volts);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_cycloid_xy_lfo: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_row_t row;
        reset_model();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset settings (outward, free, musical, zero offset)
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            push_item(row.inc, row.amt, row.dep, row.xg, row.yg, row.known, {row.x, row.y});
        end
        drain_results();

        // Random phases. The first five pin the register extremes: knob ends,
        // every range mode including the unused one, rounding and the +1 ratio,
        // unipolar on each axis (drives the saturation). Later ones write raw
        // 16-bit data so the block must ignore the upper bits.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_setting(16'(RANGE_INWARD), 16'd1, 16'd1, 16'h0000, 16'd0, 16'd0);
                1: load_setting(16'(RANGE_BIDIR), 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd1);
                2: load_setting(16'(RANGE_OUTWARD), 16'd0, 16'd1, 16'h8000, 16'd1, 16'd0);
                3: load_setting(16'(RANGE_UNUSED), 16'd1, 16'd0, 16'($urandom), 16'd0, 16'd1);
                4: load_setting(16'(RANGE_BIDIR), 16'd1, 16'd1, 16'($urandom), 16'd0, 16'd0);
                default: load_setting(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            calm = (p == 4);   // one long stretch with no idling at all
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until the pipe is empty
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_random_item();
            end
            drain_results();
            calm = 1'b0;
        end

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (err_count == 0)
            $display("tb_cycloid_xy_lfo: done, clean");
        else
            $display("tb_cycloid_xy_lfo: done, errors");
        $finish;
    end

endmodule
